FILE: src/tgd_pkg.sv
// ----------------------------------------------------------------------------
// tgd_pkg
// Shared types, register indexes, reset values and queue sizing for the
// time-of-flight hand gesture detector.
// ----------------------------------------------------------------------------
package tgd_pkg;

  localparam int DISTANCE_BITS_DEF = 13;
  localparam int CFG_DATA_W        = 16;
  localparam int CFG_INDEX_W       = 3;
  localparam int TIME_W            = 32;
  localparam int CFG_TIME_W        = 16;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int RST_VALID_MIN = 40;
  localparam int RST_VALID_MAX = 1200;
  localparam int RST_ENTER     = 175;
  localparam int RST_LEAVE     = 285;
  localparam int RST_WAVE_MIN  = 60;
  localparam int RST_WAVE_MAX  = 480;
  localparam int RST_HOLD      = 560;
  localparam int RST_DOUBLE    = 620;
  localparam int UNPRIMED_MM   = 8190;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_VALID_MIN = 3'd0,
    REG_VALID_MAX = 3'd1,
    REG_ENTER     = 3'd2,
    REG_LEAVE     = 3'd3,
    REG_WAVE_MIN  = 3'd4,
    REG_WAVE_MAX  = 3'd5,
    REG_HOLD      = 3'd6,
    REG_DOUBLE    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_NEAR    = 2'd1,
    PH_HOLDING = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_NEAR       = 3'd1,
    EV_FAR        = 3'd2,
    EV_WAVE       = 3'd3,
    EV_DOUBLE     = 3'd4,
    EV_HOLD_START = 3'd5,
    EV_HOLDING    = 3'd6,
    EV_HOLD_END   = 3'd7
  } event_t;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] wave_min;
    logic [CFG_TIME_W-1:0] wave_max;
    logic [CFG_TIME_W-1:0] hold;
    logic [CFG_TIME_W-1:0] dbl;
  } tgd_times_t;

endpackage

FILE: src/tgd_fifo.sv
// ----------------------------------------------------------------------------
// tgd_fifo
// Two-entry queue with push/full and pop/empty; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module tgd_fifo
  import tgd_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: src/tgd_front.sv
// ----------------------------------------------------------------------------
// tgd_front
// Sample front end: range check, smoothing filter and effective distance.
// ----------------------------------------------------------------------------
module tgd_front
  import tgd_pkg::*;
#(
  parameter int DISTANCE_BITS = DISTANCE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  input  logic [DISTANCE_BITS-1:0] in_distance_mm,
  input  logic [TIME_W-1:0]        in_now_ms,
  output logic                     in_full,
  input  logic [DISTANCE_BITS-1:0] valid_min,
  input  logic [DISTANCE_BITS-1:0] valid_max,
  output logic                     q_push,
  output logic [2*DISTANCE_BITS+TIME_W:0] q_data,
  input  logic                     q_full
);

  localparam int DB    = DISTANCE_BITS;
  localparam int SUM_W = DB + 2;
  localparam int SHIFT = SUM_W + 1;
  localparam int PW    = SUM_W + SHIFT;
  localparam logic [PW-1:0] RECIP3 = PW'(((1 << SHIFT) + 2) / 3);

  logic [DB-1:0]    smooth_r, smooth_nxt;
  logic             primed_r, primed_nxt;
  logic             accept;
  logic             in_window;
  logic [SUM_W-1:0] sum;
  logic [PW-1:0]    prod;
  logic [DB-1:0]    quot;
  logic [DB:0]      eff_dist;

  assign accept    = in_push & ~q_full;
  assign in_full   = q_full;
  assign q_push    = in_push;
  assign in_window = (in_distance_mm >= valid_min) && (in_distance_mm <= valid_max);
  assign sum       = {1'b0, smooth_r, 1'b0} + SUM_W'(in_distance_mm);
  assign prod      = PW'(sum) * RECIP3;
  assign quot      = prod[SHIFT +: DB];

  always_comb begin
    smooth_nxt = smooth_r;
    primed_nxt = primed_r;
    eff_dist   = {1'b0, valid_max} + 1'b1;
    if (in_window) begin
      smooth_nxt = primed_r ? quot : in_distance_mm;
      primed_nxt = 1'b1;
      eff_dist   = {1'b0, smooth_nxt};
    end
  end

  assign q_data = {eff_dist, in_now_ms, smooth_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= DB'(UNPRIMED_MM);
      primed_r <= 1'b0;
    end else if (accept) begin
      smooth_r <= smooth_nxt;
      primed_r <= primed_nxt;
    end
  end

endmodule

FILE: src/tgd_back.sv
// ----------------------------------------------------------------------------
// tgd_back
// Gesture phase machine: hysteresis, wave timing, hold tracking.
// ----------------------------------------------------------------------------
module tgd_back
  import tgd_pkg::*;
#(
  parameter int DISTANCE_BITS = DISTANCE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  logic [2*DISTANCE_BITS+TIME_W:0] q_data,
  input  logic [DISTANCE_BITS-1:0] enter_mm,
  input  logic [DISTANCE_BITS-1:0] leave_mm,
  input  tgd_times_t               times,
  output logic                     o_push,
  output logic [DISTANCE_BITS+3:0] o_data,
  input  logic                     o_full
);

  localparam int DB = DISTANCE_BITS;

  phase_t            phase_r, phase_nxt;
  logic [TIME_W-1:0] near_start_r, near_start_nxt;
  logic [TIME_W-1:0] last_wave_r, last_wave_nxt;
  event_t            ev;
  logic              step;
  logic [DB:0]       eff_mm;
  logic [TIME_W-1:0] now;
  logic [DB-1:0]     smooth;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] gap;
  logic              leaving;
  logic              near_out;

  assign {eff_mm, now, smooth} = q_data;
  assign step    = ~q_empty & ~o_full;
  assign q_pop   = step;
  assign o_push  = step;
  assign elapsed = now - near_start_r;
  assign gap     = now - last_wave_r;
  assign leaving = eff_mm > {1'b0, leave_mm};

  always_comb begin
    phase_nxt      = phase_r;
    near_start_nxt = near_start_r;
    last_wave_nxt  = last_wave_r;
    ev             = EV_NONE;
    case (phase_r)
      PH_IDLE: begin
        if (eff_mm < {1'b0, enter_mm}) begin
          phase_nxt      = PH_NEAR;
          near_start_nxt = now;
          ev             = EV_NEAR;
        end
      end
      PH_NEAR: begin
        if (leaving) begin
          phase_nxt = PH_IDLE;
          if (elapsed >= TIME_W'(times.wave_min) && elapsed <= TIME_W'(times.wave_max)) begin
            if (gap <= TIME_W'(times.dbl)) begin
              last_wave_nxt = '0;
              ev            = EV_DOUBLE;
            end else begin
              last_wave_nxt = now;
              ev            = EV_WAVE;
            end
          end else begin
            ev = EV_FAR;
          end
        end else if (elapsed >= TIME_W'(times.hold)) begin
          phase_nxt = PH_HOLDING;
          ev        = EV_HOLD_START;
        end
      end
      PH_HOLDING: begin
        if (leaving) begin
          phase_nxt = PH_IDLE;
          ev        = EV_HOLD_END;
        end else begin
          ev = EV_HOLDING;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  assign near_out = (phase_nxt == PH_NEAR) || (phase_nxt == PH_HOLDING);
  assign o_data   = {ev, smooth, near_out};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      near_start_r <= '0;
      last_wave_r  <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      near_start_r <= near_start_nxt;
      last_wave_r  <= last_wave_nxt;
    end
  end

endmodule

FILE: src/tof_hand_gesture_detector_top.sv
// ----------------------------------------------------------------------------
// tof_hand_gesture_detector_top
// Hand gesture detector for a time-of-flight distance sensor.
//
// Input channel: in_push / in_full carry one beat of {in_distance_mm,
// in_now_ms}. Result channel: out_empty / out_pop present the oldest result
// {out_gesture_event, out_filtered_distance, out_hand_near}; every input beat
// yields exactly one result beat.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_wdata; cfg_ready
// is always high. Write only while no beat is in flight.
// Throughput is one beat per cycle while the result queue has room, set by
// the combinational filter (a multiply by the reciprocal of three) in the
// front stage and the phase machine in the back stage. An accepted beat is
// registered in the sample queue; the back stage then writes the result queue.
// Reset clears both queues, the filter (reads 8190 until the first valid
// sample), the phase machine and the registers to their defaults.
// When the receiver stalls, the result queue fills, then the sample queue,
// and in_full rises after four beats are held.
// ----------------------------------------------------------------------------
module tof_hand_gesture_detector_top
  import tgd_pkg::*;
#(
  parameter int DISTANCE_BITS = DISTANCE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [DISTANCE_BITS-1:0] in_distance_mm,
  input  logic [TIME_W-1:0]        in_now_ms,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [2:0]               out_gesture_event,
  output logic [DISTANCE_BITS-1:0] out_filtered_distance,
  output logic                     out_hand_near,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int DB  = DISTANCE_BITS;
  localparam int QW  = 2*DB + TIME_W + 1;
  localparam int OW  = DB + 4;

  logic [DB-1:0] valid_min_r, valid_max_r, enter_r, leave_r;
  tgd_times_t    times_r;

  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;
  logic          o_push, o_full;
  logic [OW-1:0] o_wdata, o_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_min_r      <= DB'(RST_VALID_MIN);
      valid_max_r      <= DB'(RST_VALID_MAX);
      enter_r          <= DB'(RST_ENTER);
      leave_r          <= DB'(RST_LEAVE);
      times_r.wave_min <= CFG_TIME_W'(RST_WAVE_MIN);
      times_r.wave_max <= CFG_TIME_W'(RST_WAVE_MAX);
      times_r.hold     <= CFG_TIME_W'(RST_HOLD);
      times_r.dbl      <= CFG_TIME_W'(RST_DOUBLE);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VALID_MIN: valid_min_r      <= cfg_wdata[DB-1:0];
        REG_VALID_MAX: valid_max_r      <= cfg_wdata[DB-1:0];
        REG_ENTER:     enter_r          <= cfg_wdata[DB-1:0];
        REG_LEAVE:     leave_r          <= cfg_wdata[DB-1:0];
        REG_WAVE_MIN:  times_r.wave_min <= cfg_wdata;
        REG_WAVE_MAX:  times_r.wave_max <= cfg_wdata;
        REG_HOLD:      times_r.hold     <= cfg_wdata;
        REG_DOUBLE:    times_r.dbl      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  tgd_front #(
    .DISTANCE_BITS (DB)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_distance_mm (in_distance_mm),
    .in_now_ms      (in_now_ms),
    .in_full        (in_full),
    .valid_min      (valid_min_r),
    .valid_max      (valid_max_r),
    .q_push         (q_push),
    .q_data         (q_wdata),
    .q_full         (q_full)
  );

  tgd_fifo #(
    .W (QW)
  ) u_sample_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tgd_back #(
    .DISTANCE_BITS (DB)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_data   (q_rdata),
    .enter_mm (enter_r),
    .leave_mm (leave_r),
    .times    (times_r),
    .o_push   (o_push),
    .o_data   (o_wdata),
    .o_full   (o_full)
  );

  tgd_fifo #(
    .W (OW)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata (o_wdata),
    .full  (o_full),
    .pop   (out_pop),
    .rdata (o_rdata),
    .empty (out_empty)
  );

  assign {out_gesture_event, out_filtered_distance, out_hand_near} = o_rdata;

endmodule
